[rtl/lfgen_pkg.sv]
// Shared types and constants for the life generation row stream.
`default_nettype none

package lfgen_pkg;

  // Stream payload widths.
  localparam int ROW_W      = 64;
  localparam int ROWNUM_W   = 10;
  localparam int TDATA_IN_W = 64;
  localparam int TDATA_OUT_W = 80;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int WIDTH_REG_W = 7;
  localparam int HEIGHT_REG_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic                last_row;
    logic [ROWNUM_W-1:0] row_number;
    logic [ROW_W-1:0]    next_row_cells;
  } result_t;

endpackage

`default_nettype wire

[rtl/lfgen_row_eval.sv]
// Per-column B3/S23 evaluation of one row from the rows above and below it.
`default_nettype none

module lfgen_row_eval #(
  parameter int LANES = 64
) (
  input  wire logic [LANES-1:0] up,
  input  wire logic [LANES-1:0] mid,
  input  wire logic [LANES-1:0] down,
  input  wire logic [LANES-1:0] mask,
  output logic      [LANES-1:0] res
);

  logic [LANES+1:0] up_p;
  logic [LANES+1:0] mid_p;
  logic [LANES+1:0] down_p;

  // A dead column on each side gives the dead border.
  assign up_p   = {1'b0, up & mask, 1'b0};
  assign mid_p  = {1'b0, mid & mask, 1'b0};
  assign down_p = {1'b0, down & mask, 1'b0};

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [3:0] n;
    logic       alive;
    assign alive = mid_p[k+1];
    assign n = 4'(up_p[k]) + 4'(up_p[k+1]) + 4'(up_p[k+2]) +
               4'(mid_p[k]) + 4'(mid_p[k+2]) +
               4'(down_p[k]) + 4'(down_p[k+1]) + 4'(down_p[k+2]);
    assign res[k] = mask[k] & ((n == 4'd3) | (alive & (n == 4'd2)));
  end

endmodule

`default_nettype wire

[rtl/lfgen_out_fifo.sv]
// Small result queue; up to two pushes and one pop (when out_ready) per cycle.
`default_nettype none

module lfgen_out_fifo
  import lfgen_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_a,
  input  wire logic             push_b,
  input  wire result_t          data_a,
  input  wire result_t          data_b,
  output logic      [OQ_CW-1:0] count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_data
);

  result_t          mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_AW-1:0] wr_ptr_b;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = 2'(push_a) + 2'(push_b);
  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem[rd_ptr];
  assign wr_ptr_b  = push_a ? (wr_ptr + OQ_AW'(1)) : wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + OQ_CW'(n_push) - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= data_b;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue count above depth");

  a_double_push: assert property (@(posedge clk) disable iff (rst)
    push_a && push_b |=> count >= OQ_CW'(2))
    else $error("double push did not leave two entries");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push_a && !push_b |=> count == $past(count) - OQ_CW'(1))
    else $error("pop without push did not drop count by one");
`endif

endmodule

`default_nettype wire

[rtl/life_generation_row_stream.sv]
// An accepted row is registered into the evaluation stage, whose result beat(s) then go into
// the result queue. Input is one row per cycle while s_axis_tready is high; the final row of
// a generation can give two result beats. Ready is set by room in the four-entry result queue.
// Reset (rst, synchronous, active high) clears the stored rows, the row count, the queue
// and restores a width of 64 columns and a height of 64 rows.
`default_nettype none

module life_generation_row_stream
  import lfgen_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input rows.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [63:0] row_cells
  // Result rows.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [TDATA_OUT_W-1:0] m_axis_tdata,  // [63:0] next_row_cells, [73:64] row_number
  output logic                        m_axis_tlast   // last_row
);

  localparam int HEFF_MAX = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
  localparam int CNT_W    = $clog2(HEFF_MAX);
  localparam logic [HEIGHT_REG_W-1:0] HMAX = HEIGHT_REG_W'(HEFF_MAX);
  localparam logic [WIDTH_REG_W-1:0]  WMAX = WIDTH_REG_W'(MAX_WIDTH);

  logic [WIDTH_REG_W-1:0]  grid_width;
  logic [HEIGHT_REG_W-1:0] grid_height;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [MAX_WIDTH-1:0]    mask;

  logic [MAX_WIDTH-1:0] row_above;
  logic [MAX_WIDTH-1:0] row_held;
  logic [CNT_W-1:0]     rows_seen;

  logic                 accept;
  logic [MAX_WIDTH-1:0] cur;
  logic                 has_prev;
  logic                 final_now;

  logic                 s1_valid;
  logic [MAX_WIDTH-1:0] s1_cur;
  logic [MAX_WIDTH-1:0] s1_above;
  logic [MAX_WIDTH-1:0] s1_held;
  logic [CNT_W-1:0]     s1_idx;
  logic                 s1_mid_en;
  logic                 s1_final;
  logic [1:0]           s1_n;

  logic [MAX_WIDTH-1:0] res_mid;
  logic [MAX_WIDTH-1:0] res_last;
  logic [11:0]          idx_ext;
  result_t              data_a;
  result_t              data_b;
  result_t              out_data;
  logic [OQ_CW-1:0]     oq_count;
  logic [3:0]           room_need;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WIDTH_REG_W'(64);
      grid_height <= HEIGHT_REG_W'(64);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  grid_width  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_wdata[HEIGHT_REG_W-1:0];
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  always_comb begin
    w_eff = grid_width;
    if (grid_width == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (grid_width > WMAX) begin
      w_eff = WMAX;
    end
    h_eff = grid_height;
    if (grid_height == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (grid_height > HMAX) begin
      h_eff = HMAX;
    end
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_mask
    assign mask[k] = (WIDTH_REG_W'(k) < w_eff);
  end

  // Input side: row bookkeeping happens as the beat is taken.
  assign accept    = s_axis_tvalid & s_axis_tready;
  assign cur       = s_axis_tdata[MAX_WIDTH-1:0] & mask;
  assign has_prev  = (rows_seen != '0);
  assign final_now = ((12'(rows_seen) + 12'd1) >= {1'b0, h_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above <= '0;
      row_held  <= '0;
      rows_seen <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (final_now) begin
          row_above <= '0;
          row_held  <= '0;
          rows_seen <= '0;
        end else begin
          row_above <= has_prev ? row_held : '0;
          row_held  <= cur;
          rows_seen <= rows_seen + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur    <= cur;
      s1_above  <= row_above;
      s1_held   <= has_prev ? row_held : '0;
      s1_idx    <= rows_seen;
      s1_mid_en <= has_prev;
      s1_final  <= final_now;
    end
  end

  // Evaluation stage: the row above the new one, and the final row itself.
  lfgen_row_eval #(.LANES(MAX_WIDTH)) u_eval_mid (
    .up   (s1_above),
    .mid  (s1_held),
    .down (s1_cur),
    .mask (mask),
    .res  (res_mid)
  );

  lfgen_row_eval #(.LANES(MAX_WIDTH)) u_eval_last (
    .up   (s1_held),
    .mid  (s1_cur),
    .down ('0),
    .mask (mask),
    .res  (res_last)
  );

  assign idx_ext = 12'(s1_idx);

  always_comb begin
    data_a.next_row_cells = ROW_W'(res_mid);
    data_a.row_number     = 10'(idx_ext - 12'd1);
    data_a.last_row       = 1'b0;
    data_b.next_row_cells = ROW_W'(res_last);
    data_b.row_number     = idx_ext[ROWNUM_W-1:0];
    data_b.last_row       = 1'b1;
  end

  assign s1_n = s1_valid ? (2'(s1_mid_en) + 2'(s1_final)) : 2'd0;

  // Room for the row in evaluation and for two more results from a new row.
  assign room_need     = 4'(oq_count) + 4'(s1_n) + 4'd2;
  assign s_axis_tready = (room_need <= 4'(OQ_DEPTH));

  lfgen_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (s1_valid & s1_mid_en),
    .push_b    (s1_valid & s1_final),
    .data_a    (data_a),
    .data_b    (data_b),
    .count     (oq_count),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {6'b0, out_data.row_number, out_data.next_row_cells};
  assign m_axis_tlast = out_data.last_row;

`ifndef SYNTH
  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted row did not reach the evaluation stage");

  a_final_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && final_now |=> rows_seen == '0)
    else $error("row count did not wrap after the final row");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !final_now |=> rows_seen == $past(rows_seen) + CNT_W'(1))
    else $error("row count did not advance by one");
`endif

endmodule

`default_nettype wire

[bench/life_generation_row_stream_tb.sv]
// Self-checking testbench for the streaming life generation row block.
`default_nettype none

module life_generation_row_stream_tb;
  import lfgen_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ROWS = 700;
  localparam int SHOWN_ERRORS = 10;

  typedef enum bit {ST_ROW, ST_CFG} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  value;
    bit                typed;
    logic [ROW_W-1:0]  exp_cells;
  } stim_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;   // [63:0] row_cells
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [63:0] next_row_cells, [73:64] row_number
  logic                   m_axis_tlast;   // last_row

  life_generation_row_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow of the block: registers, the two stored rows and the row count.
  logic [WIDTH_REG_W-1:0]  grid_cols;
  logic [HEIGHT_REG_W-1:0] grid_rows;
  logic [ROW_W-1:0]        shadow_above;
  logic [ROW_W-1:0]        shadow_held;
  int                      shadow_seen;

  result_t next_rows_due[$];
  int      error_count;
  int      cycle_count;
  bit      steady;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_generation_row_stream regression: fail");
      $finish;
    end
  end

  function automatic logic [ROW_W-1:0] cols_mask();
    int w;
    w = (grid_cols == 0) ? 1 : int'(grid_cols);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int rows_per_gen();
    int h;
    h = (grid_rows == 0) ? 1 : int'(grid_rows);
    return (h > 1024) ? 1024 : h;
  endfunction

  // B3/S23 rule for row mid, with cells past the edges dead.
  function automatic logic [ROW_W-1:0] life_rule(logic [ROW_W-1:0] up, logic [ROW_W-1:0] mid,
                                                 logic [ROW_W-1:0] down, logic [ROW_W-1:0] m);
    logic [ROW_W-1:0] res;
    int n;
    res = '0;
    up = up & m;
    mid = mid & m;
    down = down & m;
    for (int k = 0; k < ROW_W; k++) begin
      n = int'(up[k]) + int'(down[k]);
      if (k > 0) n += int'(up[k-1]) + int'(mid[k-1]) + int'(down[k-1]);
      if (k < ROW_W - 1) n += int'(up[k+1]) + int'(mid[k+1]) + int'(down[k+1]);
      if (n == 3 || (mid[k] && n == 2)) res[k] = 1'b1;
    end
    return res & m;
  endfunction

  task automatic advance_generation(input logic [ROW_W-1:0] row, output int n,
                                    output result_t r0, output result_t r1);
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] cur;
    int h;
    int idx;
    result_t out [2];
    m = cols_mask();
    h = rows_per_gen();
    cur = row & m;
    idx = shadow_seen;
    n = 0;
    if (idx > 0) begin
      out[n] = '{last_row: 1'b0, row_number: ROWNUM_W'(idx - 1),
                 next_row_cells: life_rule(shadow_above, shadow_held, cur, m)};
      n++;
    end
    if (idx + 1 >= h) begin
      out[n] = '{last_row: 1'b1, row_number: ROWNUM_W'(idx),
                 next_row_cells: life_rule((idx > 0) ? shadow_held : '0, cur, '0, m)};
      n++;
      shadow_above = '0;
      shadow_held = '0;
      shadow_seen = 0;
    end else begin
      shadow_above = (idx > 0) ? shadow_held : '0;
      shadow_held = cur;
      shadow_seen = idx + 1;
    end
    r0 = out[0];
    r1 = out[1];
  endtask

  task automatic send_row(input logic [ROW_W-1:0] row, input bit typed,
                          input logic [ROW_W-1:0] exp_cells);
    int n;
    result_t r0;
    result_t r1;
    while (!steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata <= row;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    advance_generation(row, n, r0, r1);
    if (typed) begin
      next_rows_due.push_back('{last_row: 1'b1, row_number: '0, next_row_cells: exp_cells});
    end else begin
      if (n > 0) next_rows_due.push_back(r0);
      if (n > 1) next_rows_due.push_back(r1);
    end
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (next_rows_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_GRID_WIDTH) grid_cols = value[WIDTH_REG_W-1:0];
    else grid_rows = value[HEIGHT_REG_W-1:0];
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return a & b;
      1: return a | b;
      2: return '1;
      3: return '0;
      4: return a & b & c;
      default: return a;
    endcase
  endfunction

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.next_row_cells = m_axis_tdata[ROW_W-1:0];
      got.row_number = m_axis_tdata[ROW_W +: ROWNUM_W];
      got.last_row = m_axis_tlast;
      if (next_rows_due.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected beat: cells %h row %0d last %b",
                   got.next_row_cells, got.row_number, got.last_row);
      end else begin
        want = next_rows_due.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS)
            $display("mismatch: expected cells %h row %0d last %b, got cells %h row %0d last %b",
                     want.next_row_cells, want.row_number, want.last_row,
                     got.next_row_cells, got.row_number, got.last_row);
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  initial begin
    stim_t directed [29];
    int rand_rows;
    int rows_now;
    int h_now;
    int w_pick;
    int h_pick;
    logic [CFG_DATA_W-1:0] w_val;
    logic [CFG_DATA_W-1:0] h_val;

    directed = '{
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h0,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h8000_0000_0000_0001, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h7,                   1'b0, '0},
      // Height drops below the rows already taken: the next row closes the generation.
      '{ST_CFG, REG_GRID_HEIGHT, 64'd1,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
      '{ST_ROW, REG_GRID_WIDTH,  64'h0,                   1'b1, 64'h0},
      '{ST_CFG, REG_GRID_WIDTH,  64'd0,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
      '{ST_CFG, REG_GRID_WIDTH,  64'd127,                 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
      '{ST_CFG, REG_GRID_HEIGHT, 64'd0,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h7,                   1'b1, 64'h2},
      '{ST_CFG, REG_GRID_WIDTH,  64'd1,                   1'b0, '0},
      '{ST_CFG, REG_GRID_HEIGHT, 64'd2,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h1,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h1,                   1'b0, '0},
      '{ST_CFG, REG_GRID_WIDTH,  64'd3,                   1'b0, '0},
      '{ST_CFG, REG_GRID_HEIGHT, 64'd3,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h2,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h2,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'h2,                   1'b0, '0},
      '{ST_CFG, REG_GRID_WIDTH,  64'd63,                  1'b0, '0},
      '{ST_CFG, REG_GRID_HEIGHT, 64'd4,                   1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ST_ROW, REG_GRID_WIDTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0}
    };

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_addr <= REG_GRID_WIDTH;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    steady = 1'b0;
    grid_cols = 7'd64;
    grid_rows = 11'd64;
    shadow_above = '0;
    shadow_held = '0;
    shadow_seen = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ST_CFG)
        write_reg(directed[i].addr, directed[i].value[CFG_DATA_W-1:0]);
      else
        send_row(directed[i].value, directed[i].typed, directed[i].exp_cells);
    end

    // Random phases: small grids mostly, and some phases that stop mid-generation
    // so the next settings land part way in.
    rand_rows = 0;
    while (rand_rows < RANDOM_ROWS) begin
      w_pick = $urandom_range(0, 9);
      case (w_pick)
        0: w_val = 11'd0;
        1: w_val = 11'd127;
        2: w_val = 11'd64;
        3: w_val = 11'd1;
        4: w_val = CFG_DATA_W'($urandom_range(65, 127));
        default: w_val = CFG_DATA_W'($urandom_range(2, 63));
      endcase
      h_pick = $urandom_range(0, 19);
      case (h_pick)
        0: h_val = 11'd0;
        1: h_val = 11'd1;
        2: h_val = 11'd2047;
        3: h_val = CFG_DATA_W'($urandom_range(0, 2047));
        default: h_val = CFG_DATA_W'($urandom_range(2, 10));
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_WIDTH, w_val);
      if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_HEIGHT, h_val);
      h_now = rows_per_gen();
      if (h_now > 16)
        rows_now = $urandom_range(1, 30);
      else
        rows_now = $urandom_range(1, 3 * h_now);
      steady = rand_rows >= 200 && rand_rows < 320;
      for (int r = 0; r < rows_now; r++) send_row(random_row(), 1'b0, '0);
      steady = 1'b0;
      rand_rows += rows_now;
    end

    s_axis_tvalid <= 1'b0;
    while (next_rows_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("life_generation_row_stream regression: pass");
    end else begin
      $display("life_generation_row_stream regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
